[sv/cmag_pkg.sv]
// shared types, widths and constants for the complex magnitude and phase core
package cmag_pkg;

    localparam int SAMPLE_WIDTH  = 24;
    localparam int PHASE_WIDTH   = 16;
    localparam int CONFIG_WIDTH  = 24;
    localparam int CORDIC_STEPS  = 24;
    localparam int SQRT_STEPS    = SAMPLE_WIDTH;
    localparam int CHAIN_DEPTH   = (SQRT_STEPS > CORDIC_STEPS) ? SQRT_STEPS : CORDIC_STEPS;
    localparam int SQ_WIDTH      = 2 * SAMPLE_WIDTH;
    localparam int REM_WIDTH     = SAMPLE_WIDTH + 2;
    localparam int SCALE_SHIFT   = 16;
    localparam int ROT_WIDTH     = SAMPLE_WIDTH + SCALE_SHIFT + 3;
    localparam int ANGLE_WIDTH   = 26;
    localparam int PHASE_GUARD   = 9;
    localparam int PHASE_WIDE    = ANGLE_WIDTH - PHASE_GUARD;
    localparam int PHASE_LIMIT   = 16384;

    localparam logic [CONFIG_WIDTH-1:0] ZERO_MAG_RESET = CONFIG_WIDTH'(8389);
    localparam logic signed [ANGLE_WIDTH-1:0] ROUND_BIAS =
        ANGLE_WIDTH'(1 << (PHASE_GUARD - 1));
    localparam logic signed [PHASE_WIDE-1:0] WIDE_LIMIT_POS = PHASE_WIDE'(PHASE_LIMIT);
    localparam logic signed [PHASE_WIDE-1:0] WIDE_LIMIT_NEG = -WIDE_LIMIT_POS;
    localparam logic signed [PHASE_WIDTH-1:0] PHASE_POS = PHASE_WIDTH'(PHASE_LIMIT);
    localparam logic signed [PHASE_WIDTH-1:0] PHASE_NEG = -PHASE_POS;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] real_part;
        logic signed [SAMPLE_WIDTH-1:0] imag_part;
        logic                           last_pair;
    } in_word_t;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0]       magnitude;
        logic signed [PHASE_WIDTH-1:0] phase;
        logic                          last_result;
    } out_word_t;

    typedef struct packed {
        logic [SQ_WIDTH-1:0]            sq;
        logic [REM_WIDTH-1:0]           rem;
        logic [SAMPLE_WIDTH-1:0]        root;
        logic signed [ROT_WIDTH-1:0]    x;
        logic signed [ROT_WIDTH-1:0]    y;
        logic signed [ANGLE_WIDTH-1:0]  z;
        logic                           re_zero;
        logic                           im_zero;
        logic                           im_neg;
        logic                           last;
    } cell_word_t;

    // round(atan(2^-i) / pi * 2^24)
    function automatic logic [ANGLE_WIDTH-1:0] atan_unit(input int unsigned step);
        logic [ANGLE_WIDTH-1:0] value;
        case (step)
            0:       value = ANGLE_WIDTH'(4194304);
            1:       value = ANGLE_WIDTH'(2476042);
            2:       value = ANGLE_WIDTH'(1308273);
            3:       value = ANGLE_WIDTH'(664100);
            4:       value = ANGLE_WIDTH'(333339);
            5:       value = ANGLE_WIDTH'(166832);
            6:       value = ANGLE_WIDTH'(83436);
            7:       value = ANGLE_WIDTH'(41721);
            8:       value = ANGLE_WIDTH'(20861);
            9:       value = ANGLE_WIDTH'(10430);
            10:      value = ANGLE_WIDTH'(5215);
            11:      value = ANGLE_WIDTH'(2608);
            12:      value = ANGLE_WIDTH'(1304);
            13:      value = ANGLE_WIDTH'(652);
            14:      value = ANGLE_WIDTH'(326);
            15:      value = ANGLE_WIDTH'(163);
            16:      value = ANGLE_WIDTH'(81);
            17:      value = ANGLE_WIDTH'(41);
            18:      value = ANGLE_WIDTH'(20);
            19:      value = ANGLE_WIDTH'(10);
            20:      value = ANGLE_WIDTH'(5);
            21:      value = ANGLE_WIDTH'(3);
            22:      value = ANGLE_WIDTH'(1);
            23:      value = ANGLE_WIDTH'(1);
            default: value = '0;
        endcase
        return value;
    endfunction

endpackage

[sv/complex_magnitude_and_phase_core.sv]
// top level: front stage, chain of root and rotator cells, output register
// Takes one complex bin per clock and returns its rounded magnitude and its phase in units of
// pi/32768, one word per clock sustained. The path has two input stages (squares and
// their sum), a chain of 24 cells that each resolve one magnitude bit and one rotation, and the
// output register. The whole chain advances together; it only holds when the output word is
// stalled and the last cell has a word ready, so in_stall follows out_stall in that one case.
// zero_magnitude is the magnitude given for an all-zero bin; write it only while idle.
module complex_magnitude_and_phase_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  cmag_pkg::in_word_t                  in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output cmag_pkg::out_word_t                 out_word,
    input  logic                                zero_magnitude_write,
    input  logic [cmag_pkg::CONFIG_WIDTH-1:0]   zero_magnitude_data
);

    localparam int DEPTH = cmag_pkg::CHAIN_DEPTH;

    logic                                  enable;
    logic                                  chain_valid [0:DEPTH];
    cmag_pkg::cell_word_t                  chain_word  [0:DEPTH];
    cmag_pkg::cell_word_t                  tail;
    logic [cmag_pkg::CONFIG_WIDTH-1:0]     zero_mag_reg;
    logic                                  out_valid_reg;
    cmag_pkg::out_word_t                   out_word_reg;
    cmag_pkg::out_word_t                   out_word_next;
    logic                                  round_up;
    logic signed [cmag_pkg::ANGLE_WIDTH-1:0] z_biased;
    logic signed [cmag_pkg::PHASE_WIDE-1:0]  phase_wide;
    logic signed [cmag_pkg::PHASE_WIDE-1:0]  phase_clamped;

    assign enable   = !(out_valid_reg && out_stall && chain_valid[DEPTH]);
    assign in_stall = !enable;

    cmag_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (enable),
        .in_valid    (in_valid),
        .in_word     (in_word),
        .front_valid (chain_valid[0]),
        .front_word  (chain_word[0])
    );

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        cmag_cell
        #(
            .STEP (k)
        )
        u_cell
        (
            .clk            (clk),
            .rst_n          (rst_n),
            .enable         (enable),
            .cell_in_valid  (chain_valid[k]),
            .cell_in        (chain_word[k]),
            .cell_out_valid (chain_valid[k+1]),
            .cell_out       (chain_word[k+1])
        );
    end

    assign tail = chain_word[DEPTH];

    always_comb
    begin
        // round to nearest: remainder above root means the true root is past root + 1/2
        round_up = (tail.rem > cmag_pkg::REM_WIDTH'(tail.root));

        z_biased   = tail.z + cmag_pkg::ROUND_BIAS;
        phase_wide = z_biased[cmag_pkg::ANGLE_WIDTH-1:cmag_pkg::PHASE_GUARD];
        if (phase_wide > cmag_pkg::WIDE_LIMIT_POS)
        begin
            phase_clamped = cmag_pkg::WIDE_LIMIT_POS;
        end
        else if (phase_wide < cmag_pkg::WIDE_LIMIT_NEG)
        begin
            phase_clamped = cmag_pkg::WIDE_LIMIT_NEG;
        end
        else
        begin
            phase_clamped = phase_wide;
        end

        out_word_next.last_result = tail.last;
        if (tail.re_zero && tail.im_zero)
        begin
            out_word_next.magnitude = zero_mag_reg[cmag_pkg::SAMPLE_WIDTH-1:0];
            out_word_next.phase     = '0;
        end
        else
        begin
            out_word_next.magnitude = tail.root + cmag_pkg::SAMPLE_WIDTH'(round_up);
            if (tail.re_zero)
            begin
                out_word_next.phase = tail.im_neg ? cmag_pkg::PHASE_NEG : cmag_pkg::PHASE_POS;
            end
            else
            begin
                out_word_next.phase = phase_clamped[cmag_pkg::PHASE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_mag_reg <= cmag_pkg::ZERO_MAG_RESET;
        end
        else if (zero_magnitude_write)
        begin
            zero_mag_reg <= zero_magnitude_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= chain_valid[DEPTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[sv/cmag_front.sv]
// input conditioning: squares, sum of squares and rotator start values
module cmag_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  enable,
    input  logic                  in_valid,
    input  cmag_pkg::in_word_t    in_word,
    output logic                  front_valid,
    output cmag_pkg::cell_word_t  front_word
);

    typedef struct packed {
        logic [cmag_pkg::SQ_WIDTH-1:0]         sq_re;
        logic [cmag_pkg::SQ_WIDTH-1:0]         sq_im;
        logic signed [cmag_pkg::ROT_WIDTH-1:0] x;
        logic signed [cmag_pkg::ROT_WIDTH-1:0] y;
        logic                                  re_zero;
        logic                                  im_zero;
        logic                                  im_neg;
        logic                                  last;
    } square_word_t;

    logic                                  sq_valid_reg;
    square_word_t                          sq_word_reg;
    square_word_t                          sq_word_next;
    logic                                  front_valid_reg;
    cmag_pkg::cell_word_t                  front_word_reg;
    cmag_pkg::cell_word_t                  front_word_next;
    logic [cmag_pkg::SAMPLE_WIDTH-1:0]     abs_re;
    logic [cmag_pkg::SAMPLE_WIDTH-1:0]     abs_im;
    logic signed [cmag_pkg::ROT_WIDTH-1:0] im_ext;
    logic signed [cmag_pkg::ROT_WIDTH-1:0] y_pre;

    always_comb
    begin
        abs_re = in_word.real_part[cmag_pkg::SAMPLE_WIDTH-1] ?
                 -in_word.real_part : in_word.real_part;
        abs_im = in_word.imag_part[cmag_pkg::SAMPLE_WIDTH-1] ?
                 -in_word.imag_part : in_word.imag_part;
        im_ext = cmag_pkg::ROT_WIDTH'(in_word.imag_part);
        y_pre  = in_word.real_part[cmag_pkg::SAMPLE_WIDTH-1] ? -im_ext : im_ext;

        sq_word_next.sq_re   = abs_re * abs_re;
        sq_word_next.sq_im   = abs_im * abs_im;
        sq_word_next.x       = $signed(cmag_pkg::ROT_WIDTH'(abs_re) << cmag_pkg::SCALE_SHIFT);
        sq_word_next.y       = y_pre <<< cmag_pkg::SCALE_SHIFT;
        sq_word_next.re_zero = (in_word.real_part == '0);
        sq_word_next.im_zero = (in_word.imag_part == '0);
        sq_word_next.im_neg  = in_word.imag_part[cmag_pkg::SAMPLE_WIDTH-1];
        sq_word_next.last    = in_word.last_pair;
    end

    always_comb
    begin
        front_word_next.sq      = sq_word_reg.sq_re + sq_word_reg.sq_im;
        front_word_next.rem     = '0;
        front_word_next.root    = '0;
        front_word_next.x       = sq_word_reg.x;
        front_word_next.y       = sq_word_reg.y;
        front_word_next.z       = '0;
        front_word_next.re_zero = sq_word_reg.re_zero;
        front_word_next.im_zero = sq_word_reg.im_zero;
        front_word_next.im_neg  = sq_word_reg.im_neg;
        front_word_next.last    = sq_word_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg    <= 1'b0;
            front_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            sq_valid_reg    <= in_valid;
            front_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            sq_word_reg    <= sq_word_next;
            front_word_reg <= front_word_next;
        end
    end

    assign front_valid = front_valid_reg;
    assign front_word  = front_word_reg;

endmodule

[sv/cmag_cell.sv]
// one cell of the chain: a root digit step and a rotator micro-rotation
module cmag_cell
#(
    parameter int STEP = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  enable,
    input  logic                  cell_in_valid,
    input  cmag_pkg::cell_word_t  cell_in,
    output logic                  cell_out_valid,
    output cmag_pkg::cell_word_t  cell_out
);

    localparam logic [cmag_pkg::ANGLE_WIDTH-1:0] ANGLE = cmag_pkg::atan_unit(STEP);

    logic                  valid_reg;
    cmag_pkg::cell_word_t  word_reg;
    cmag_pkg::cell_word_t  word_next;

    logic [cmag_pkg::REM_WIDTH-1:0]        rem_shift;
    logic [cmag_pkg::REM_WIDTH-1:0]        trial;
    logic signed [cmag_pkg::ROT_WIDTH-1:0] x_in;
    logic signed [cmag_pkg::ROT_WIDTH-1:0] y_in;
    logic signed [cmag_pkg::ROT_WIDTH-1:0] x_sh;
    logic signed [cmag_pkg::ROT_WIDTH-1:0] y_sh;

    always_comb
    begin
        word_next = cell_in;

        // square root digit: bring down two bits, try (root << 2) | 1
        rem_shift = {cell_in.rem[cmag_pkg::REM_WIDTH-3:0],
                     cell_in.sq[cmag_pkg::SQ_WIDTH-1 -: 2]};
        trial     = {cell_in.root, 2'b01};
        if (STEP < cmag_pkg::SQRT_STEPS)
        begin
            word_next.sq = cell_in.sq << 2;
            if (rem_shift >= trial)
            begin
                word_next.rem  = rem_shift - trial;
                word_next.root = {cell_in.root[cmag_pkg::SAMPLE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                word_next.rem  = rem_shift;
                word_next.root = {cell_in.root[cmag_pkg::SAMPLE_WIDTH-2:0], 1'b0};
            end
        end

        // vectoring micro-rotation towards the positive x axis
        x_in = cell_in.x;
        y_in = cell_in.y;
        x_sh = x_in >>> STEP;
        y_sh = y_in >>> STEP;
        if (STEP < cmag_pkg::CORDIC_STEPS)
        begin
            if (!y_in[cmag_pkg::ROT_WIDTH-1])
            begin
                word_next.x = x_in + y_sh;
                word_next.y = y_in - x_sh;
                word_next.z = cell_in.z + $signed(ANGLE);
            end
            else
            begin
                word_next.x = x_in - y_sh;
                word_next.y = y_in + x_sh;
                word_next.z = cell_in.z - $signed(ANGLE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= cell_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            word_reg <= word_next;
        end
    end

    assign cell_out_valid = valid_reg;
    assign cell_out       = word_reg;

endmodule

[sv/cmag_checker.sv]
// port-level checks for the complex magnitude and phase core, with its bind
module cmag_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  cmag_pkg::in_word_t                  in_word,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  cmag_pkg::out_word_t                 out_word
);

    // a held input word stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_word))
        else $error("input word changed while stalled");

    // a held output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // input only backs up behind a stalled output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output was free");

    // the input side is not stalled in a cycle in which the output word is taken
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> !in_stall)
        else $error("input stalled while output word was taken");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(out_word.phase) <= cmag_pkg::PHASE_LIMIT)
                   && ($signed(out_word.phase) >= -cmag_pkg::PHASE_LIMIT))
        else $error("phase outside plus or minus half pi");

endmodule

bind complex_magnitude_and_phase_core cmag_checker u_cmag_checker (.*);

[test/complex_magnitude_and_phase_core_tb.sv]
`timescale 1ns / 100ps
// testbench for the complex magnitude and phase core: random and corner bins against a predictor
module complex_magnitude_and_phase_core_tb;

    typedef logic signed [cmag_pkg::SAMPLE_WIDTH-1:0] sample_t;

    localparam sample_t SAMPLE_MAX   = sample_t'(24'sh7FFFFF);
    localparam sample_t SAMPLE_MIN   = sample_t'(24'sh800000);
    localparam int      PIPE_LATENCY = 27;
    localparam int      QUIET_LIMIT  = 4000;
    localparam int      RANDOM_BINS  = 250;

    localparam longint CORDIC_ANGLE [cmag_pkg::CORDIC_STEPS] = '{
        4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
        20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1
    };

    class polar_scoreboard;
        cmag_pkg::out_word_t                   pending_polar[$];
        logic [cmag_pkg::CONFIG_WIDTH-1:0]     zero_level;
        int                                    mismatches;

        function new(logic [cmag_pkg::CONFIG_WIDTH-1:0] level);
            zero_level = level;
            mismatches = 0;
        endfunction

        function cmag_pkg::out_word_t polar_of(cmag_pkg::in_word_t w);
            longint              re;
            longint              im;
            longint              x;
            longint              y;
            longint              z;
            longint              xs;
            longint              ys;
            longint              turn;
            longint unsigned     sq;
            longint unsigned     root;
            longint unsigned     rest;
            longint unsigned     probe;
            cmag_pkg::out_word_t r;
            re = longint'(w.real_part);
            im = longint'(w.imag_part);
            r.last_result = w.last_pair;
            if (re == 0 && im == 0)
            begin
                r.magnitude = zero_level[cmag_pkg::SAMPLE_WIDTH-1:0];
                r.phase = '0;
                return r;
            end
            sq = re * re + im * im;
            root = 0;
            rest = sq;
            probe = 64'd1 << 62;
            while (probe > rest)
                probe = probe >> 2;
            while (probe != 0)
            begin
                if (rest >= root + probe)
                begin
                    rest = rest - (root + probe);
                    root = (root >> 1) + probe;
                end
                else
                begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            if (rest > root)
                root = root + 1;
            r.magnitude = root[cmag_pkg::SAMPLE_WIDTH-1:0];
            if (re == 0)
            begin
                r.phase = (im > 0) ? cmag_pkg::PHASE_POS : cmag_pkg::PHASE_NEG;
            end
            else
            begin
                x = ((re < 0) ? -re : re) * 65536;
                y = ((re < 0) ? -im : im) * 65536;
                z = 0;
                for (int i = 0; i < cmag_pkg::CORDIC_STEPS; i++)
                begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0)
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + CORDIC_ANGLE[i];
                    end
                    else
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - CORDIC_ANGLE[i];
                    end
                end
                turn = (z + (64'sd1 << (cmag_pkg::PHASE_GUARD - 1))) >>> cmag_pkg::PHASE_GUARD;
                if (turn > cmag_pkg::PHASE_LIMIT)
                    turn = cmag_pkg::PHASE_LIMIT;
                if (turn < -cmag_pkg::PHASE_LIMIT)
                    turn = -cmag_pkg::PHASE_LIMIT;
                r.phase = turn[cmag_pkg::PHASE_WIDTH-1:0];
            end
            return r;
        endfunction

        function void note_input(cmag_pkg::in_word_t w);
            pending_polar.push_back(polar_of(w));
        endfunction

        function void check_result(cmag_pkg::out_word_t got);
            cmag_pkg::out_word_t want;
            if (pending_polar.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: magnitude %0d phase %0d last %0b",
                             got.magnitude, got.phase, got.last_result);
                return;
            end
            want = pending_polar.pop_front();
            if (got.magnitude !== want.magnitude || got.phase !== want.phase
                || got.last_result !== want.last_result)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: magnitude %0d/%0d phase %0d/%0d",
                              " last %0b/%0b (exp/act)"},
                             want.magnitude, got.magnitude, want.phase, got.phase,
                             want.last_result, got.last_result);
            end
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    cmag_pkg::in_word_t                in_word;
    logic                              out_valid;
    logic                              out_stall;
    cmag_pkg::out_word_t               out_word;
    logic                              zero_magnitude_write;
    logic [cmag_pkg::CONFIG_WIDTH-1:0] zero_magnitude_data;

    polar_scoreboard board = new(cmag_pkg::ZERO_MAG_RESET);
    int send_idle = 0;
    int recv_idle = 0;
    int quiet_cycles = 0;

    complex_magnitude_and_phase_core i_dut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .in_word              (in_word),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .out_word             (out_word),
        .zero_magnitude_write (zero_magnitude_write),
        .zero_magnitude_data  (zero_magnitude_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver back-pressure, changed on the falling edge
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_word);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic sample_t random_part();
        case ($urandom_range(7))
            0:       return '0;
            1:       return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            2:       return sample_t'(int'($urandom_range(32)) - 16);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_bin(input cmag_pkg::in_word_t w);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_word = w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(w);
        @(negedge clk);
    endtask

    task automatic send_parts(input sample_t re, input sample_t im, input logic last);
        cmag_pkg::in_word_t w;
        w.real_part = re;
        w.imag_part = im;
        w.last_pair = last;
        send_bin(w);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_parts(random_part(), random_part(), ($urandom_range(7) == 0));
        in_valid = 1'b0;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (board.pending_polar.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_level(input logic [cmag_pkg::CONFIG_WIDTH-1:0] level);
        zero_magnitude_write = 1'b1;
        zero_magnitude_data = level;
        board.zero_level = level;
        @(negedge clk);
        zero_magnitude_write = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        zero_magnitude_write = 1'b0;
        zero_magnitude_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner bins with the reset floor
        send_idle = 12;
        recv_idle = 48;
        send_parts('0, '0, 1'b0);
        send_parts('0, SAMPLE_MAX, 1'b0);
        send_parts('0, SAMPLE_MIN, 1'b1);
        send_parts('0, 24'sd1, 1'b0);
        send_parts('0, -24'sd1, 1'b0);
        send_parts(SAMPLE_MAX, '0, 1'b0);
        send_parts(SAMPLE_MIN, '0, 1'b0);
        send_parts(-24'sd5, '0, 1'b1);
        send_parts(24'sd1, '0, 1'b0);
        send_parts(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_parts(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_parts(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_parts(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_parts(24'sd1, 24'sd1, 1'b0);
        send_parts(-24'sd1, -24'sd1, 1'b0);
        send_parts(24'sd1, SAMPLE_MAX, 1'b0);
        send_parts(-24'sd1, SAMPLE_MIN, 1'b0);
        send_parts(24'sd1, SAMPLE_MIN, 1'b0);
        send_parts(-24'sd1, SAMPLE_MAX, 1'b0);
        send_parts(24'sd3000000, -24'sd4000000, 1'b0);
        send_parts(-24'sd3000000, 24'sd4000000, 1'b1);
        send_parts(-24'sd7, 24'sd2, 1'b0);
        send_parts('0, '0, 1'b1);
        drain();

        write_level('0);
        send_random(RANDOM_BINS);
        drain();

        send_idle = 48;
        recv_idle = 12;
        write_level({cmag_pkg::CONFIG_WIDTH{1'b1}});
        send_parts('0, '0, 1'b0);
        send_random(RANDOM_BINS);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_level(cmag_pkg::CONFIG_WIDTH'($urandom));
        send_parts('0, '0, 1'b1);
        send_random(RANDOM_BINS);
        drain();

        // catch any stray words after the last expected one
        repeat (PIPE_LATENCY + 8) @(negedge clk);
        if (board.mismatches == 0 && board.pending_polar.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
